FILE: rtl/core/ssp_pkg.sv
package ssp_pkg;

   // graph capacity
   localparam int MAX_VERTICES = 64;
   localparam int MAX_EDGES    = 256;
   localparam int WEIGHT_BITS  = 16;

   // fixed field widths
   localparam int VIDX_BITS  = 6;
   localparam int VCNT_BITS  = 7;
   localparam int DIST_BITS  = 22;
   localparam int EADDR_BITS = $clog2(MAX_EDGES);
   localparam int ECNT_BITS  = $clog2(MAX_EDGES + 1);
   localparam int SUM_BITS   = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
   localparam int EDGE_BITS  = 2 * VIDX_BITS + WEIGHT_BITS;

   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   // command codes carried in req_tuser
   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_RUN   = 2'd2,
      CMD_NONE  = 2'd3
   } ssp_cmd_type;

   // result error codes
   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_START    = 2'd2;

   // register index of vertex_count
   localparam logic REG_VERTEX_COUNT = 1'b0;

   localparam logic [VCNT_BITS-1:0] VCOUNT_RESET = VCNT_BITS'(MAX_VERTICES);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MIN_RD,
      ST_MIN_CMP,
      ST_MARK,
      ST_REL_RD,
      ST_REL_CHK,
      ST_REL_UPD,
      ST_OUT_RD,
      ST_OUT_LOAD,
      ST_OUT_SEND,
      ST_ERR_SEND
   } ssp_state_type;

endpackage

FILE: rtl/core/ssp_ram.sv
module ssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: rtl/core/ssp_alu.sv
module ssp_alu import ssp_pkg::*; (
   input  logic                   add_en,
   input  logic [DIST_BITS-1:0]   op_a,
   input  logic [WEIGHT_BITS-1:0] op_b,
   input  logic [DIST_BITS-1:0]   op_c,
   output logic [DIST_BITS-1:0]   result,
   output logic                   less
);

   logic [SUM_BITS-1:0] sum;

   // saturating add when enabled (else pass the first operand), then compare against the third operand
   always_comb begin
      sum = SUM_BITS'(op_a) + SUM_BITS'(op_b);
      if (!add_en) begin
         result = op_a;
      end else if (sum > SUM_BITS'(DIST_MAX)) begin
         result = DIST_MAX;
      end else begin
         result = sum[DIST_BITS-1:0];
      end
      less = (result < op_c);
   end

endmodule

FILE: rtl/core/single_source_shortest_paths_unit.sv
// run: one pass per vertex in use, each a minimum search over the vertices and a
//   relaxation over the stored edges, then one result per vertex, plus output stalls;
//   passes stop early once no reached vertex is left; a bad start gives its one result
//   the cycle after the transfer
// clear and add-edge commands complete in the idle state and are taken back to back
// the edge table has one read port; a single add/compare unit serves search and relaxation
// reset (synchronous, active high): edge table empty, overflow clear, vertex_count 64, idle
module single_source_shortest_paths_unit import ssp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // edge_source, edge_dest, edge_weight, start_vertex, pad
   input  logic [1:0]  req_tuser,   // cmd
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // vertex_index, distance, reachable, error, pad
   output logic        rsp_tlast,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   ssp_state_type state_ff, state_in;

   logic [VCNT_BITS-1:0]    vcount_ff, vcount_in;
   logic [ECNT_BITS-1:0]    ecount_ff, ecount_in;
   logic                    ovf_ff, ovf_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [VCNT_BITS-1:0]    nv_ff, nv_in;
   logic [VCNT_BITS-1:0]    pass_ff, pass_in;
   logic [VIDX_BITS-1:0]    vidx_ff, vidx_in;
   logic [ECNT_BITS-1:0]    eidx_ff, eidx_in;
   logic                    found_ff, found_in;
   logic [DIST_BITS-1:0]    best_ff, best_in;
   logic [VIDX_BITS-1:0]    mvert_ff, mvert_in;
   logic [MAX_VERTICES-1:0] reached_ff, reached_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;

   logic [VIDX_BITS-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [DIST_BITS-1:0]    rsp_dist_ff, rsp_dist_in;
   logic                    rsp_reach_ff, rsp_reach_in;
   logic [1:0]              rsp_err_ff, rsp_err_in;
   logic                    rsp_last_ff, rsp_last_in;

   // input fields
   ssp_cmd_type          req_cmd;
   logic [VIDX_BITS-1:0] req_src, req_dst, req_start;
   logic [15:0]          req_weight;
   logic                 req_xfer;

   // memory ports
   logic                   edge_wr_en, edge_rd_en;
   logic [EDGE_BITS-1:0]   edge_wr_data, edge_rd_data;
   logic [EADDR_BITS-1:0]  edge_rd_addr;
   logic                   dist_wr_en, dist_rd_en;
   logic [VIDX_BITS-1:0]   dist_wr_addr, dist_rd_addr;
   logic [DIST_BITS-1:0]   dist_wr_data, dist_rd_data;

   // stored edge fields
   logic [VIDX_BITS-1:0]   e_src, e_dst;
   logic [WEIGHT_BITS-1:0] e_weight;

   // shared unit
   logic                   alu_add;
   logic [DIST_BITS-1:0]   alu_a, alu_c, alu_result;
   logic [WEIGHT_BITS-1:0] alu_b;
   logic                   alu_less;

   logic [VCNT_BITS-1:0]   nv_cfg;
   logic                   csr_wr;
   logic                   cand_ok;

   assign req_cmd    = ssp_cmd_type'(req_tuser);
   assign req_src    = req_tdata[5:0];
   assign req_dst    = req_tdata[11:6];
   assign req_weight = req_tdata[27:12];
   assign req_start  = req_tdata[33:28];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   assign e_src    = edge_rd_data[VIDX_BITS-1:0];
   assign e_dst    = edge_rd_data[2*VIDX_BITS-1:VIDX_BITS];
   assign e_weight = edge_rd_data[EDGE_BITS-1:2*VIDX_BITS];

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_VERTEX_COUNT) ? 32'(vcount_ff) : '0;

   // vertex count in use, clamped to 1..MAX_VERTICES
   always_comb begin
      if (vcount_ff == '0) begin
         nv_cfg = VCNT_BITS'(1);
      end else if (vcount_ff > VCNT_BITS'(MAX_VERTICES)) begin
         nv_cfg = VCNT_BITS'(MAX_VERTICES);
      end else begin
         nv_cfg = vcount_ff;
      end
   end

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, rsp_err_ff, rsp_reach_ff, rsp_dist_ff, rsp_idx_ff};

   ssp_ram #(.WIDTH(EDGE_BITS), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (ecount_ff[EADDR_BITS-1:0]),
      .wr_data (edge_wr_data),
      .rd_en   (edge_rd_en),
      .rd_addr (edge_rd_addr),
      .rd_data (edge_rd_data)
   );

   ssp_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_VERTICES)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_wr_en),
      .wr_addr (dist_wr_addr),
      .wr_data (dist_wr_data),
      .rd_en   (dist_rd_en),
      .rd_addr (dist_rd_addr),
      .rd_data (dist_rd_data)
   );

   ssp_alu u_alu (
      .add_en (alu_add),
      .op_a   (alu_a),
      .op_b   (alu_b),
      .op_c   (alu_c),
      .result (alu_result),
      .less   (alu_less)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= VCOUNT_RESET;
         ecount_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         ecount_ff    <= ecount_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload registers
   always_ff @(posedge clock) begin
      nv_ff        <= nv_in;
      pass_ff      <= pass_in;
      vidx_ff      <= vidx_in;
      eidx_ff      <= eidx_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      mvert_ff     <= mvert_in;
      reached_ff   <= reached_in;
      visited_ff   <= visited_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_reach_ff <= rsp_reach_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      ecount_in    = ecount_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      nv_in        = nv_ff;
      pass_in      = pass_ff;
      vidx_in      = vidx_ff;
      eidx_in      = eidx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      mvert_in     = mvert_ff;
      reached_in   = reached_ff;
      visited_in   = visited_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_reach_in = rsp_reach_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;

      edge_wr_en   = 1'b0;
      edge_wr_data = {WEIGHT_BITS'(req_weight), req_dst, req_src};
      edge_rd_en   = 1'b0;
      edge_rd_addr = eidx_ff[EADDR_BITS-1:0];
      dist_wr_en   = 1'b0;
      dist_wr_addr = e_dst;
      dist_wr_data = alu_result;
      dist_rd_en   = 1'b0;
      dist_rd_addr = vidx_ff;

      alu_add = 1'b0;
      alu_a   = dist_rd_data;
      alu_b   = e_weight;
      alu_c   = best_ff;
      cand_ok = 1'b0;

      // register write
      if (csr_wr && (csr_paddr[2] == REG_VERTEX_COUNT)) begin
         vcount_in = csr_pwdata[VCNT_BITS-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (req_cmd)
                  CMD_CLEAR: begin
                     ecount_in = '0;
                     ovf_in    = 1'b0;
                  end
                  CMD_ADD: begin
                     if (ecount_ff < ECNT_BITS'(MAX_EDGES)) begin
                        edge_wr_en = 1'b1;
                        ecount_in  = ecount_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  CMD_RUN: begin
                     if (VCNT_BITS'(req_start) >= nv_cfg) begin
                        rsp_idx_in   = req_start;
                        rsp_dist_in  = '0;
                        rsp_reach_in = 1'b0;
                        rsp_err_in   = ERR_START;
                        rsp_last_in  = 1'b1;
                        rsp_valid_in = 1'b1;
                        state_in     = ST_ERR_SEND;
                     end else begin
                        nv_in      = nv_cfg;
                        pass_in    = '0;
                        vidx_in    = '0;
                        found_in   = 1'b0;
                        reached_in = '0;
                        reached_in[req_start] = 1'b1;
                        visited_in = '0;
                        // start vertex sits at distance zero
                        dist_wr_en   = 1'b1;
                        dist_wr_addr = req_start;
                        dist_wr_data = '0;
                        state_in   = ST_MIN_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // minimum search over vertices
         ST_MIN_RD: begin
            dist_rd_en = 1'b1;
            state_in   = ST_MIN_CMP;
         end

         ST_MIN_CMP: begin
            cand_ok = reached_ff[vidx_ff] && !visited_ff[vidx_ff] && (!found_ff || alu_less);
            if (cand_ok) begin
               found_in = 1'b1;
               best_in  = dist_rd_data;
               mvert_in = vidx_ff;
            end
            if (VCNT_BITS'(vidx_ff) == nv_ff - 1'b1) begin
               vidx_in = '0;
               // no reached vertex left: later passes change nothing
               state_in = (found_ff || cand_ok) ? ST_MARK : ST_OUT_RD;
            end else begin
               vidx_in  = vidx_ff + 1'b1;
               state_in = ST_MIN_RD;
            end
         end

         ST_MARK: begin
            visited_in[mvert_ff] = 1'b1;
            eidx_in  = '0;
            state_in = ST_REL_RD;
         end

         // relaxation over stored edges
         ST_REL_RD: begin
            if (eidx_ff == ecount_ff) begin
               vidx_in = '0;
               if (pass_ff == nv_ff - 1'b1) begin
                  state_in = ST_OUT_RD;
               end else begin
                  pass_in  = pass_ff + 1'b1;
                  found_in = 1'b0;
                  state_in = ST_MIN_RD;
               end
            end else begin
               edge_rd_en = 1'b1;
               state_in   = ST_REL_CHK;
            end
         end

         ST_REL_CHK: begin
            if ((e_src == mvert_ff) && (VCNT_BITS'(e_dst) < nv_ff) && !visited_ff[e_dst]) begin
               dist_rd_en   = 1'b1;
               dist_rd_addr = e_dst;
               state_in     = ST_REL_UPD;
            end else begin
               eidx_in  = eidx_ff + 1'b1;
               state_in = ST_REL_RD;
            end
         end

         ST_REL_UPD: begin
            alu_add = 1'b1;
            alu_a   = best_ff;
            alu_c   = dist_rd_data;
            if (!reached_ff[e_dst] || alu_less) begin
               dist_wr_en          = 1'b1;
               reached_in[e_dst]   = 1'b1;
            end
            eidx_in  = eidx_ff + 1'b1;
            state_in = ST_REL_RD;
         end

         // one result per vertex
         ST_OUT_RD: begin
            dist_rd_en = 1'b1;
            state_in   = ST_OUT_LOAD;
         end

         ST_OUT_LOAD: begin
            rsp_idx_in   = vidx_ff;
            rsp_dist_in  = reached_ff[vidx_ff] ? dist_rd_data : DIST_MAX;
            rsp_reach_in = reached_ff[vidx_ff];
            rsp_err_in   = ovf_ff ? ERR_OVERFLOW : ERR_OK;
            rsp_last_in  = (VCNT_BITS'(vidx_ff) == nv_ff - 1'b1);
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT_SEND;
         end

         ST_OUT_SEND: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  vidx_in  = vidx_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end

         ST_ERR_SEND: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/ssp_checker.sv
module ssp_checker import ssp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // no new item taken while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a result is pending");

   // a bad start is a run of one result
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[30:29] == ERR_START) |-> rsp_tlast && !rsp_tdata[28])
      else $error("start error result not marked last");

   // unreached vertices report a saturated distance
   a_unreached: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[28] && (rsp_tdata[30:29] != ERR_START)
      |-> (rsp_tdata[27:6] == DIST_MAX))
      else $error("unreached vertex with finite distance");

   // block comes out of reset ready
   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

endmodule

bind single_source_shortest_paths_unit ssp_checker u_ssp_checker (.*);
